FILE: sv/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types, constants and helper functions for the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    // Steps in one hue sector and the number of pipeline stages
    localparam int unsigned SectorSteps = 43;
    localparam int unsigned NumStages   = 5;

    // Reciprocal of 43 for ramp products up to 255*43: floor(x/43) = (x*M) >> 20
    localparam int unsigned RecipShift  = 20;
    localparam logic [14:0] Recip43     = 15'd24386;

    // Hue sector codes
    localparam logic [2:0] SECT_RED_UP   = 3'd0;
    localparam logic [2:0] SECT_GRN_DOM  = 3'd1;
    localparam logic [2:0] SECT_GRN_UP   = 3'd2;
    localparam logic [2:0] SECT_BLU_DOM  = 3'd3;
    localparam logic [2:0] SECT_BLU_UP   = 3'd4;

    // One input pixel
    typedef struct packed {
        logic [7:0] alpha_in;
        logic [7:0] brightness;
        logic [7:0] saturation;
        logic [7:0] hue;
    } hsv_pix_t;

    // One output pixel
    typedef struct packed {
        logic [7:0] alpha_out;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_pix_t;

    // Pipeline control from the top level to the datapath
    typedef struct packed {
        logic advance;
    } pipe_ctrl_t;

    // Sector index of a hue: count of sector boundaries at or below it
    function automatic logic [2:0] hue_sector(input logic [7:0] h);
        logic [2:0] s;
        s = 3'd0;
        if (h >= 8'd43)  s = 3'd1;
        if (h >= 8'd86)  s = 3'd2;
        if (h >= 8'd129) s = 3'd3;
        if (h >= 8'd172) s = 3'd4;
        if (h >= 8'd215) s = 3'd5;
        return s;
    endfunction

    // First hue of a sector
    function automatic logic [7:0] sector_base(input logic [2:0] s);
        logic [7:0] b;
        case (s)
            3'd0:    b = 8'd0;
            3'd1:    b = 8'd43;
            3'd2:    b = 8'd86;
            3'd3:    b = 8'd129;
            3'd4:    b = 8'd172;
            default: b = 8'd215;
        endcase
        return b;
    endfunction

endpackage

FILE: sv/hsv2rgb_core.sv
// ----------------------------------------------------------------------------
// hsv2rgb_core
// Five-stage datapath: product, chroma, ramp product, ramp divide, channel mux.
// ----------------------------------------------------------------------------
module hsv2rgb_core (
    input  logic                    aclk,
    input  hsv2rgb_pkg::pipe_ctrl_t ctrl,
    input  hsv2rgb_pkg::hsv_pix_t   pix_in,
    output hsv2rgb_pkg::rgb_pix_t   pix_out
);

    // Stage 1: v*s product, sector split
    logic [15:0] vs_prod_reg;
    logic [2:0]  sect1_reg;
    logic [5:0]  offs1_reg;
    logic [7:0]  val1_reg;
    logic [7:0]  alpha1_reg;
    logic [2:0]  sect1_next;
    logic [7:0]  offs1_full;

    assign sect1_next = hsv2rgb_pkg::hue_sector(pix_in.hue);
    assign offs1_full = pix_in.hue - hsv2rgb_pkg::sector_base(sect1_next);

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            vs_prod_reg <= 16'(pix_in.brightness) * 16'(pix_in.saturation);
            sect1_reg   <= sect1_next;
            offs1_reg   <= offs1_full[5:0];
            val1_reg    <= pix_in.brightness;
            alpha1_reg  <= pix_in.alpha_in;
        end
    end

    // Stage 2: chroma = floor(p/255), ramp multiplier from sector parity
    logic [7:0]  chroma2_reg;
    logic [5:0]  mult2_reg;
    logic [2:0]  sect2_reg;
    logic [7:0]  val2_reg;
    logic [7:0]  alpha2_reg;
    logic [16:0] div255_sum;
    logic [5:0]  mult2_next;

    // floor(p/255) = (p + (p >> 8) + 1) >> 8 for any p up to 255*255
    assign div255_sum = 17'(vs_prod_reg) + 17'(vs_prod_reg[15:8]) + 17'd1;
    assign mult2_next = sect1_reg[0] ? 6'(6'(hsv2rgb_pkg::SectorSteps) - offs1_reg)
                                     : offs1_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            chroma2_reg <= div255_sum[15:8];
            mult2_reg   <= mult2_next;
            sect2_reg   <= sect1_reg;
            val2_reg    <= val1_reg;
            alpha2_reg  <= alpha1_reg;
        end
    end

    // Stage 3: ramp product and minimum level
    logic [13:0] ramp_prod3_reg;
    logic [7:0]  chroma3_reg;
    logic [7:0]  min3_reg;
    logic [2:0]  sect3_reg;
    logic [7:0]  alpha3_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            ramp_prod3_reg <= 14'(chroma2_reg) * 14'(mult2_reg);
            chroma3_reg    <= chroma2_reg;
            min3_reg       <= val2_reg - chroma2_reg;
            sect3_reg      <= sect2_reg;
            alpha3_reg     <= alpha2_reg;
        end
    end

    // Stage 4: ramp = floor(prod/43) by reciprocal multiply
    logic [28:0] recip_prod;
    logic [7:0]  ramp4_reg;
    logic [7:0]  chroma4_reg;
    logic [7:0]  min4_reg;
    logic [2:0]  sect4_reg;
    logic [7:0]  alpha4_reg;

    assign recip_prod = 29'(ramp_prod3_reg) * 29'(hsv2rgb_pkg::Recip43);

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            ramp4_reg   <= recip_prod[hsv2rgb_pkg::RecipShift +: 8];
            chroma4_reg <= chroma3_reg;
            min4_reg    <= min3_reg;
            sect4_reg   <= sect3_reg;
            alpha4_reg  <= alpha3_reg;
        end
    end

    // Stage 5: route chroma/ramp/zero to channels, add minimum level
    logic [7:0] r_share;
    logic [7:0] g_share;
    logic [7:0] b_share;
    hsv2rgb_pkg::rgb_pix_t out_reg;

    always_comb begin
        unique case (sect4_reg)
            hsv2rgb_pkg::SECT_RED_UP: begin
                r_share = chroma4_reg; g_share = ramp4_reg;   b_share = 8'd0;
            end
            hsv2rgb_pkg::SECT_GRN_DOM: begin
                r_share = ramp4_reg;   g_share = chroma4_reg; b_share = 8'd0;
            end
            hsv2rgb_pkg::SECT_GRN_UP: begin
                r_share = 8'd0;        g_share = chroma4_reg; b_share = ramp4_reg;
            end
            hsv2rgb_pkg::SECT_BLU_DOM: begin
                r_share = 8'd0;        g_share = ramp4_reg;   b_share = chroma4_reg;
            end
            hsv2rgb_pkg::SECT_BLU_UP: begin
                r_share = ramp4_reg;   g_share = 8'd0;        b_share = chroma4_reg;
            end
            // last sector, magenta to red
            default: begin
                r_share = chroma4_reg; g_share = 8'd0;        b_share = ramp4_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            out_reg.red       <= r_share + min4_reg;
            out_reg.green     <= g_share + min4_reg;
            out_reg.blue      <= b_share + min4_reg;
            out_reg.alpha_out <= alpha4_reg;
        end
    end

    assign pix_out = out_reg;

endmodule

FILE: sv/hsv_to_rgb_8bit_unit.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_8bit_unit
// Stream converter from 8-bit HSV plus alpha to 8-bit RGB plus alpha.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output is not stalled and returns one
// item per item, in order. Each item passes through the five register stages
// of the datapath (v*s product, divide by 255, ramp product, reciprocal
// divide by 43, channel routing); the last stage is the output register. The
// whole pipeline holds while a result waits and m_tready is low; an empty
// output stage always lets a new item in.
module hsv_to_rgb_8bit_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // hue, saturation, brightness, alpha_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // red, green, blue, alpha_out
);

    localparam int unsigned NStg = hsv2rgb_pkg::NumStages;

    hsv2rgb_pkg::pipe_ctrl_t ctrl;
    hsv2rgb_pkg::hsv_pix_t   pix_in;
    hsv2rgb_pkg::rgb_pix_t   pix_out;
    logic [NStg-1:0]         vld_reg;

    // Pipeline moves whenever the output slot is free or being emptied
    assign ctrl.advance = m_tready || !vld_reg[NStg-1];
    assign s_tready     = ctrl.advance;

    // Valid bits alongside the data stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ctrl.advance) begin
            vld_reg <= {vld_reg[NStg-2:0], s_tvalid};
        end
    end

    // Unpack item fields
    assign pix_in.hue        = s_tdata[7:0];
    assign pix_in.saturation = s_tdata[15:8];
    assign pix_in.brightness = s_tdata[23:16];
    assign pix_in.alpha_in   = s_tdata[31:24];

    hsv2rgb_core u_core (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .pix_in  (pix_in),
        .pix_out (pix_out)
    );

    assign m_tvalid = vld_reg[NStg-1];
    assign m_tdata  = {pix_out.alpha_out, pix_out.blue, pix_out.green, pix_out.red};

endmodule

FILE: sv/hsv2rgb_checker.sv
// ----------------------------------------------------------------------------
// hsv2rgb_checker
// Port-level assertions for the HSV to RGB converter, bound to the top level.
// ----------------------------------------------------------------------------
module hsv2rgb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // An empty or draining output stage never blocks the input
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input blocked with free output");

    // An accepted item reaches the output while m_tready stays high behind it
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready
        ##1 m_tready |=> m_tvalid)
        else $error("item lost in pipeline");

endmodule

bind hsv_to_rgb_8bit_unit hsv2rgb_checker u_hsv2rgb_chk (.*);

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the HSV to RGB stream converter against a local colour predictor.
// A directed set of pixels covers the sector edges, grey and black levels and
// the extremes of each field. A long random stream follows, sent in bursts,
// while the result side stalls at random and once holds off long enough to
// back the pipeline up into its input.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FullScale   = 255;
    localparam int unsigned RandomItems = 1950;
    localparam int unsigned CycleLimit  = 200000;
    localparam int unsigned HoldStart   = 1000;
    localparam int unsigned HoldCycles  = 300;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // hue, saturation, brightness, alpha_in
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // red, green, blue, alpha_out

    hsv2rgb_pkg::hsv_pix_t pixel_q[$];          // items waiting to be sent
    hsv2rgb_pkg::rgb_pix_t expected_rgb_q[$];   // colours owed by the block, oldest first

    int unsigned error_count    = 0;
    int unsigned pixels_sent    = 0;
    int unsigned pixels_checked = 0;
    int unsigned sector_hits[6] = '{default: 0};
    int unsigned cycle_count    = 0;

    hsv_to_rgb_8bit_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock
    initial begin
        forever #4 aclk = ~aclk;
    end

    // Expected RGB of one HSV pixel, truncating integer arithmetic
    function automatic hsv2rgb_pkg::rgb_pix_t predict_rgb(hsv2rgb_pkg::hsv_pix_t px);
        int unsigned chroma;
        int unsigned base_lvl;
        int unsigned sector;
        int unsigned offs;
        int unsigned ramp;
        int unsigned r, g, b;
        hsv2rgb_pkg::rgb_pix_t res;
        chroma   = (px.brightness * px.saturation) / FullScale;
        base_lvl = px.brightness - chroma;
        sector   = px.hue / hsv2rgb_pkg::SectorSteps;
        offs     = px.hue - sector * hsv2rgb_pkg::SectorSteps;
        // rising ramp on even sectors, falling on odd ones
        if (sector[0] == 1'b0) begin
            ramp = (chroma * offs) / hsv2rgb_pkg::SectorSteps;
        end else begin
            ramp = (chroma * (hsv2rgb_pkg::SectorSteps - offs)) / hsv2rgb_pkg::SectorSteps;
        end
        case (sector)
            hsv2rgb_pkg::SECT_RED_UP: begin
                r = chroma; g = ramp;   b = 0;
            end
            hsv2rgb_pkg::SECT_GRN_DOM: begin
                r = ramp;   g = chroma; b = 0;
            end
            hsv2rgb_pkg::SECT_GRN_UP: begin
                r = 0;      g = chroma; b = ramp;
            end
            hsv2rgb_pkg::SECT_BLU_DOM: begin
                r = 0;      g = ramp;   b = chroma;
            end
            hsv2rgb_pkg::SECT_BLU_UP: begin
                r = ramp;   g = 0;      b = chroma;
            end
            default: begin
                // last sector, hue 215..255: ramp stays above zero for chroma of 15 or more
                r = chroma; g = 0;      b = ramp;
            end
        endcase
        res.red       = 8'(r + base_lvl);
        res.green     = 8'(g + base_lvl);
        res.blue      = 8'(b + base_lvl);
        res.alpha_out = px.alpha_in;
        return res;
    endfunction

    task automatic add_pixel(input int unsigned h, input int unsigned s,
                             input int unsigned v, input int unsigned a);
        hsv2rgb_pkg::hsv_pix_t px;
        px.hue        = 8'(h);
        px.saturation = 8'(s);
        px.brightness = 8'(v);
        px.alpha_in   = 8'(a);
        pixel_q.push_back(px);
    endtask

    // Random pixel, biased towards sector edges and level extremes
    function automatic int unsigned pick_level();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic int unsigned pick_hue();
        int unsigned edge_hue;
        edge_hue = $urandom_range(0, 5) * hsv2rgb_pkg::SectorSteps;
        case ($urandom_range(0, 5))
            0:       return edge_hue;
            1:       return (edge_hue == 0) ? 255 : edge_hue - 1;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // Sender: bursts of items separated by random gaps
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_rgb_q.push_back(predict_rgb(hsv2rgb_pkg::hsv_pix_t'(s_tdata)));
                sector_hits[s_tdata[7:0] / hsv2rgb_pkg::SectorSteps]++;
                pixels_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    s_tdata  <= pixel_q.pop_front();
                    s_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: own stall pattern, plus one long hold-off
    int unsigned rx_cycles     = 0;
    int unsigned hold_left     = 0;
    int unsigned rx_mode       = 0;
    int unsigned rx_mode_left  = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            rx_cycles++;
            if (rx_cycles == HoldStart) begin
                hold_left = HoldCycles;
            end
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 2);
                rx_mode_left = $urandom_range(10, 120);
            end else begin
                rx_mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Result check against the oldest expected colour
    always @(posedge aclk) begin
        hsv2rgb_pkg::rgb_pix_t got;
        hsv2rgb_pkg::rgb_pix_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = hsv2rgb_pkg::rgb_pix_t'(m_tdata);
            if (expected_rgb_q.size() == 0) begin
                $display("%0t: unexpected item, got %h", $time, m_tdata);
                error_count++;
            end else begin
                want = expected_rgb_q.pop_front();
                pixels_checked++;
                if (got.red != want.red) begin
                    $display("%0t: red mismatch, expected %0d, got %0d",
                             $time, want.red, got.red);
                    error_count++;
                end
                if (got.green != want.green) begin
                    $display("%0t: green mismatch, expected %0d, got %0d",
                             $time, want.green, got.green);
                    error_count++;
                end
                if (got.blue != want.blue) begin
                    $display("%0t: blue mismatch, expected %0d, got %0d",
                             $time, want.blue, got.blue);
                    error_count++;
                end
                if (got.alpha_out != want.alpha_out) begin
                    $display("%0t: alpha mismatch, expected %0d, got %0d",
                             $time, want.alpha_out, got.alpha_out);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("%0t: timeout with %0d items outstanding", $time,
                     expected_rgb_q.size());
            $display("FAIL hsv_to_rgb_8bit_unit");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin
        // extremes of every field
        add_pixel(0, 0, 0, 0);
        add_pixel(255, 255, 255, 255);
        // both sides of every sector edge at full colour
        add_pixel(0, 255, 255, 8'h55);
        add_pixel(42, 255, 255, 8'hAA);
        add_pixel(43, 255, 255, 1);
        add_pixel(85, 255, 255, 2);
        add_pixel(86, 255, 255, 4);
        add_pixel(128, 255, 255, 8);
        add_pixel(129, 255, 255, 16);
        add_pixel(171, 255, 255, 32);
        add_pixel(172, 255, 255, 64);
        add_pixel(214, 255, 255, 128);
        // last sector: short, ramp stays above zero
        add_pixel(215, 255, 255, 254);
        add_pixel(255, 200, 180, 253);
        // grey: no saturation
        add_pixel(100, 0, 200, 8'h5A);
        add_pixel(200, 0, 255, 8'hA5);
        // black with full saturation, and the faintest colour
        add_pixel(60, 255, 0, 255);
        add_pixel(30, 255, 1, 0);
        // mid-sector colours
        add_pixel(21, 128, 128, 1);
        add_pixel(107, 255, 128, 128);
        add_pixel(236, 200, 77, 127);
        add_pixel(150, 17, 240, 3);

        for (int unsigned i = 0; i < RandomItems; i++) begin
            add_pixel(pick_hue(), pick_level(), pick_level(), $urandom_range(0, 255));
        end

        aresetn = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (pixel_q.size() > 0 || s_tvalid) @(posedge aclk);
        while (expected_rgb_q.size() > 0) @(posedge aclk);
        repeat (4 * hsv2rgb_pkg::NumStages) @(posedge aclk);

        if (expected_rgb_q.size() > 0) begin
            $display("%0t: %0d expected items never arrived", $time,
                     expected_rgb_q.size());
            error_count++;
        end
        $display("Converted %0d pixels, %0d checked, %0d mismatches", pixels_sent,
                 pixels_checked, error_count);
        $display("Pixels per hue sector: %0d %0d %0d %0d %0d %0d", sector_hits[0],
                 sector_hits[1], sector_hits[2], sector_hits[3], sector_hits[4],
                 sector_hits[5]);
        if (error_count == 0) begin
            $display("PASS hsv_to_rgb_8bit_unit");
        end else begin
            $display("FAIL hsv_to_rgb_8bit_unit");
        end
        $finish;
    end

endmodule
